@@ design/huffman_tree_builder_core_defines.svh @@
// Assertion macros used by the core design file.
`ifndef HUFFMAN_TREE_BUILDER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_BUILDER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define HTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define HTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/htb_pkg.sv @@
package htb_pkg;
    localparam int MaxLeaves  = 32;
    localparam int WeightBits = 16;
    localparam int AddrW      = $clog2(MaxLeaves);
    localparam int CntW       = $clog2(MaxLeaves + 1);
    localparam int IdW        = 9;
    localparam int WW         = 21;
    localparam logic [WW-1:0] WMax = {WW{1'b1}};

    typedef struct packed {
        logic [IdW-1:0] id;
        logic [WW-1:0]  w;
    } t_entry;

    typedef enum logic [3:0] {
        S_LOAD, S_SD_RD, S_SD_PAR, S_SD_KID, S_SD_CMP,
        S_MG_RD, S_MG_SEL, S_MG_OUT, S_RO_RD, S_RO_OUT, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_HEAPIFY, M_SLOT, M_ROOT
    } t_sift_mode;
endpackage

@@ design/htb_ram.sv @@
module htb_ram
    import htb_pkg::*;
#(
    parameter int Depth = 32,
    parameter int AW    = 5,
    parameter int DW    = 30
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);
    logic [DW-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

@@ design/huffman_tree_builder_core.sv @@
// Leaf beats load one per cycle. Per level moved, a sift-down reads the children of the
// moving entry, then compares and writes. A heap of N leaves is built by sift-downs from
// slot (N-1)/2 back to the root; a merge sends its record, then sifts down at the merge
// slot (unless it was the last entry) and at the root. A single leaf gives its record via
// S_RO_RD and S_RO_OUT. Throughput: one tree at a time; input stalls from the last beat
// until the last record is taken, and each merge waits until the previous record is taken.
// Reset: synchronous active-low i_rst_n clears the control state; heap memory is not cleared.
`include "huffman_tree_builder_core_defines.svh"
module huffman_tree_builder_core
    import htb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_symbol,
    input  logic [15:0]          i_weight,
    input  logic                 i_last,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [IdW-1:0]       o_left_node,
    output logic [IdW-1:0]       o_right_node,
    output logic [IdW-1:0]       o_new_node,
    output logic [WW-1:0]        o_merged_weight,
    output logic                 o_root_only,
    output logic                 o_final_res
);
    // One synchronous memory holds the heap; both read ports are registered. Every read is
    // issued in a later cycle than the write that it depends on, so no forwarding is needed.
    // A sift-down keeps the moving entry in r_par and writes it once at its final slot; each
    // level writes the lighter child into the parent slot.
    t_state           r_state, n_state;
    t_sift_mode       r_mode, n_mode;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [7:0]       r_nxt, n_nxt;
    logic [AddrW-1:0] r_hi, n_hi;      // heapify cursor
    logic [AddrW-1:0] r_si, n_si;      // sift-down position
    logic [AddrW-1:0] r_m, n_m;        // merge slot
    t_entry           r_par, n_par;
    t_entry           r_rgt, n_rgt;
    logic             r_ov, n_ov;
    logic [IdW-1:0]   r_ol, n_ol, r_or, n_or, r_on, n_on;
    logic [WW-1:0]    r_ow, n_ow;
    logic             r_oro, n_oro, r_ofin, n_ofin;

    logic             we;
    logic [AddrW-1:0] waddr, ra, rb;
    t_entry           wdata, da, db;

    htb_ram #(.Depth(MaxLeaves), .AW(AddrW), .DW(IdW + WW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra), .i_raddr_b(rb), .o_rdata_a(da), .o_rdata_b(db)
    );

    logic [AddrW+1:0] c1, c2, cnt_x;
    logic             c_has1, c_has2, pick1, sift_done;
    t_entry           mine, new_ent;
    logic [AddrW-1:0] mpos;
    logic [CntW-1:0]  cnt_m1, ld_m1;
    logic [WW:0]      sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_nxt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_nxt   <= n_nxt;
            r_ov    <= n_ov;
        end
        r_mode <= n_mode; r_hi <= n_hi; r_si <= n_si; r_m <= n_m;
        r_par <= n_par; r_rgt <= n_rgt;
        r_ol <= n_ol; r_or <= n_or; r_on <= n_on; r_ow <= n_ow;
        r_oro <= n_oro; r_ofin <= n_ofin;
    end

    assign o_stall = (r_state != S_LOAD) || r_ov;
    assign o_valid = r_ov;
    assign o_left_node = r_ol;
    assign o_right_node = r_or;
    assign o_new_node = r_on;
    assign o_merged_weight = r_ow;
    assign o_root_only = r_oro;
    assign o_final_res = r_ofin;

    always_comb begin
        n_state = r_state; n_mode = r_mode; n_cnt = r_cnt; n_nxt = r_nxt; n_hi = r_hi;
        n_si = r_si; n_m = r_m; n_par = r_par; n_rgt = r_rgt; n_ov = r_ov && i_stall;
        n_ol = r_ol; n_or = r_or; n_on = r_on; n_ow = r_ow; n_oro = r_oro; n_ofin = r_ofin;
        we = 1'b0; waddr = '0; wdata = '0; ra = '0; rb = '0;
        ld_m1 = '0;
        sift_done = 1'b0;
        c1 = {1'b0, r_si, 1'b1};
        c2 = c1 + 1'b1;
        cnt_x = (AddrW+2)'(r_cnt);
        c_has1 = c1 < cnt_x;
        c_has2 = c2 < cnt_x;
        // The lighter child; the right one wins ties, and a lone left child is taken.
        pick1 = !c_has2 || (da.w < db.w);
        mine = pick1 ? da : db;
        mpos = pick1 ? c1[AddrW-1:0] : c2[AddrW-1:0];
        cnt_m1 = r_cnt - 1'b1;
        sum = {1'b0, da.w} + {1'b0, r_rgt.w};
        new_ent.id = {1'b1, r_nxt};
        new_ent.w = sum[WW] ? WMax : sum[WW-1:0];
        unique case (r_state)
            S_LOAD: begin
                if (i_valid && !o_stall) begin
                    // Leaves beyond the heap size are dropped.
                    if (r_cnt < CntW'(MaxLeaves)) begin
                        we = 1'b1;
                        waddr = r_cnt[AddrW-1:0];
                        wdata.id = {1'b0, i_symbol};
                        wdata.w = WW'(i_weight[WeightBits-1:0]);
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (i_last) begin
                        ld_m1 = n_cnt - 1'b1;
                        n_state = S_DONE;
                        if (n_cnt == CntW'(1)) begin
                            n_state = S_RO_RD;
                        end else if (n_cnt >= CntW'(2)) begin
                            n_hi = ld_m1[AddrW:1];
                            n_si = ld_m1[AddrW:1];
                            n_mode = M_HEAPIFY;
                            n_state = S_SD_RD;
                        end
                    end
                end
            end
            S_RO_RD: begin
                ra = '0;
                n_state = S_RO_OUT;
            end
            S_RO_OUT: begin
                n_ol = da.id; n_or = '0; n_on = '0; n_ow = da.w;
                n_oro = 1'b1; n_ofin = 1'b1;
                n_ov = 1'b1;
                n_state = S_DONE;
            end
            S_SD_RD: begin
                if (c_has1) begin
                    ra = r_si;
                    n_state = S_SD_PAR;
                end else begin
                    sift_done = 1'b1;
                end
            end
            S_SD_PAR: begin
                n_par = da;
                ra = c1[AddrW-1:0];
                rb = c_has2 ? c2[AddrW-1:0] : c1[AddrW-1:0];
                n_state = S_SD_CMP;
            end
            S_SD_KID: begin
                if (c_has1) begin
                    ra = c1[AddrW-1:0];
                    rb = c_has2 ? c2[AddrW-1:0] : c1[AddrW-1:0];
                    n_state = S_SD_CMP;
                end else begin
                    we = 1'b1;
                    waddr = r_si;
                    wdata = r_par;
                    sift_done = 1'b1;
                end
            end
            S_SD_CMP: begin
                we = 1'b1;
                waddr = r_si;
                if (mine.w < r_par.w) begin
                    wdata = mine;
                    n_si = mpos;
                    n_state = S_SD_KID;
                end else begin
                    wdata = r_par;
                    sift_done = 1'b1;
                end
            end
            S_MG_RD: begin
                // Read slots 1 and 2 once the previous record is gone.
                if (!r_ov) begin
                    ra = AddrW'(1);
                    rb = (r_cnt > CntW'(2)) ? AddrW'(2) : AddrW'(1);
                    n_state = S_MG_SEL;
                end
            end
            S_MG_SEL: begin
                // Slot 1 wins ties; with two nodes both ports read slot 1.
                if (da.w <= db.w) begin
                    n_m = AddrW'(1);
                    n_rgt = da;
                end else begin
                    n_m = AddrW'(2);
                    n_rgt = db;
                end
                ra = '0;
                rb = cnt_m1[AddrW-1:0];
                n_state = S_MG_OUT;
            end
            S_MG_OUT: begin
                n_ol = da.id;
                n_or = r_rgt.id;
                n_on = new_ent.id;
                n_ow = new_ent.w;
                n_oro = 1'b0;
                n_ofin = (r_cnt == CntW'(2));
                n_ov = 1'b1;
                n_nxt = r_nxt + 1'b1;
                n_cnt = cnt_m1;
                if (r_cnt == CntW'(2)) begin
                    n_state = S_DONE;
                end else if (r_m == cnt_m1[AddrW-1:0]) begin
                    // The merge slot was the last entry, so the new node moves to the root.
                    we = 1'b1;
                    waddr = '0;
                    wdata = new_ent;
                    n_si = '0;
                    n_mode = M_ROOT;
                    n_state = S_SD_RD;
                end else begin
                    // The last entry moves to the root; the new node sifts from its slot.
                    we = 1'b1;
                    waddr = '0;
                    wdata = db;
                    n_par = new_ent;
                    n_si = r_m;
                    n_mode = M_SLOT;
                    n_state = S_SD_KID;
                end
            end
            S_DONE: begin
                if (!r_ov) begin
                    n_cnt = '0; n_nxt = '0;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
        // A finished sift-down moves on to the next heapify slot, the root, the next merge or the done state.
        if (sift_done) begin
            unique case (r_mode)
                M_HEAPIFY: begin
                    if (r_hi == '0) begin
                        n_state = S_MG_RD;
                    end else begin
                        n_hi = r_hi - 1'b1;
                        n_si = r_hi - 1'b1;
                        n_state = S_SD_RD;
                    end
                end
                M_SLOT: begin
                    n_mode = M_ROOT;
                    n_si = '0;
                    n_state = S_SD_RD;
                end
                M_ROOT: begin
                    n_state = (r_cnt >= CntW'(2)) ? S_MG_RD : S_DONE;
                end
                default: n_state = S_DONE;
            endcase
        end
    end

    `HTB_ASSERT_NEXT(a_ov_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_left_node) && $stable(o_merged_weight))
    `HTB_ASSERT_IMP(a_no_load_busy, i_clk, i_rst_n, r_state != S_LOAD, o_stall)
    `HTB_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CntW'(MaxLeaves))
    `HTB_ASSERT_IMP(a_load_idle_out, i_clk, i_rst_n, r_state == S_LOAD, !o_valid)
endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the Huffman tree builder core.
// Leaf beats go in through a valid/stall port. The builder emits one merge record per
// merge on a second valid/stall port. A behavioral copy of the min-heap algorithm runs
// beside the core and predicts every record. Each record that the core sends out is
// checked field by field against the oldest prediction still waiting.
module tb_top;
    import htb_pkg::*;

    // Result fields of one merge record, kept in the order that they are expected.
    typedef struct {
        logic [IdW-1:0] left_id;
        logic [IdW-1:0] right_id;
        logic [IdW-1:0] new_id;
        logic [WW-1:0]  weight;
        logic           root_only;
        logic           final_rec;
    } t_merge_rec;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [7:0]           i_symbol;
    logic [15:0]          i_weight;
    logic                 i_last;
    logic                 o_valid;
    logic                 i_stall;
    logic [IdW-1:0]       o_left_node;
    logic [IdW-1:0]       o_right_node;
    logic [IdW-1:0]       o_new_node;
    logic [WW-1:0]        o_merged_weight;
    logic                 o_root_only;
    logic                 o_final_res;

    huffman_tree_builder_core dut (.*);

    // Predictor state: a private copy of the heap arrays and the counters.
    logic [IdW-1:0] heap_id [MaxLeaves];
    logic [WW-1:0]  heap_w  [MaxLeaves];
    int             heap_cnt;
    int             int_next;

    t_merge_rec pending_recs[$];
    int  error_count;
    int  beats_sent;
    int  recs_seen;
    int  trees_built;
    bit  sending_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One mismatch produces one line and bumps the error count.
    task automatic report_mismatch(input string what, input longint got, input longint exp);
        error_count++;
        $display("ERROR t=%0t record %0d: %s got %0d expected %0d",
                 $time, recs_seen, what, got, exp);
    endtask

    function automatic void swap_entries(input int a, input int b);
        logic [IdW-1:0] tid;
        logic [WW-1:0]  tw;
        tid = heap_id[a];
        tw = heap_w[a];
        heap_id[a] = heap_id[b];
        heap_w[a] = heap_w[b];
        heap_id[b] = tid;
        heap_w[b] = tw;
    endfunction

    // Sift-down: a parent swaps with its smaller child. On equal children the right
    // one wins, and the swap happens only when the child is strictly lighter.
    function automatic void sift_down(input int start);
        int i;
        int c1;
        int c2;
        int m;
        i = start;
        while (2 * i + 1 < heap_cnt) begin
            c1 = 2 * i + 1;
            c2 = (c1 + 1 < heap_cnt) ? c1 + 1 : c1;
            m = (heap_w[c1] < heap_w[c2]) ? c1 : c2;
            if (heap_w[m] >= heap_w[i]) break;
            swap_entries(m, i);
            i = m;
        end
    endfunction

    function automatic void rebuild_heap();
        if (heap_cnt >= 2) begin
            for (int i = (heap_cnt - 1) / 2; i >= 0; i--) sift_down(i);
        end
    endfunction

    // Takes one leaf beat and pushes every merge record that it causes.
    function automatic void predict_leaf(input logic [7:0] sym, input logic [15:0] wt,
                                         input logic lst);
        t_merge_rec r;
        int alt;
        int m;
        logic [WW:0] sum;
        if (heap_cnt < MaxLeaves) begin
            heap_id[heap_cnt] = {1'b0, sym};
            heap_w[heap_cnt] = WW'(wt);
            heap_cnt++;
        end
        if (!lst) return;
        if (heap_cnt == 1) begin
            r = '{heap_id[0], '0, '0, heap_w[0], 1'b1, 1'b1};
            pending_recs.push_back(r);
        end else if (heap_cnt >= 2) begin
            rebuild_heap();
            while (heap_cnt >= 2) begin
                alt = (heap_cnt > 2) ? 2 : 1;
                m = (heap_w[1] <= heap_w[alt]) ? 1 : alt;
                sum = {1'b0, heap_w[0]} + {1'b0, heap_w[m]};
                r.left_id = heap_id[0];
                r.right_id = heap_id[m];
                r.new_id = IdW'(256 + int_next);
                r.weight = sum[WW] ? WMax : sum[WW-1:0];
                r.root_only = 1'b0;
                int_next = (int_next + 1) & 8'hFF;
                heap_id[m] = r.new_id;
                heap_w[m] = r.weight;
                heap_cnt--;
                swap_entries(0, heap_cnt);
                rebuild_heap();
                r.final_rec = (heap_cnt == 1);
                pending_recs.push_back(r);
            end
        end
        if (lst) trees_built++;
        heap_cnt = 0;
        int_next = 0;
    endfunction

    // Most gaps are short and a few are long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sends one leaf beat and holds it until the core takes it. The prediction is made
    // at the edge that accepts the beat. Valid drops only for a gap before the next beat.
    task automatic send_leaf(input logic [7:0] sym, input logic [15:0] wt, input logic lst,
                             input bit use_gaps = 1'b1);
        int gap;
        gap = use_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_symbol <= sym;
        i_weight <= wt;
        i_last <= lst;
        do @(posedge i_clk); while (o_stall);
        predict_leaf(sym, wt, lst);
        beats_sent++;
    endtask

    // Sends a whole tree of n leaves with random symbols and weights up to wmax.
    task automatic send_tree(input int n, input int wmax, input bit use_gaps = 1'b1);
        for (int k = 0; k < n; k++)
            send_leaf(8'($urandom_range(0, 255)), 16'($urandom_range(0, wmax)),
                      k == n - 1, use_gaps);
    endtask

    // Receiver side: random stalls, and a check of each record that is taken.
    initial begin
        t_merge_rec exp_rec;
        i_stall <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_recs.size() == 0) begin
                    report_mismatch("unexpected record, queue size", 1, 0);
                end else begin
                    exp_rec = pending_recs.pop_front();
                    if (o_left_node !== exp_rec.left_id)
                        report_mismatch("left_node", o_left_node, exp_rec.left_id);
                    if (o_right_node !== exp_rec.right_id)
                        report_mismatch("right_node", o_right_node, exp_rec.right_id);
                    if (o_new_node !== exp_rec.new_id)
                        report_mismatch("new_node", o_new_node, exp_rec.new_id);
                    if (o_merged_weight !== exp_rec.weight)
                        report_mismatch("merged_weight", o_merged_weight, exp_rec.weight);
                    if (o_root_only !== exp_rec.root_only)
                        report_mismatch("root_only", o_root_only, exp_rec.root_only);
                    if (o_final_res !== exp_rec.final_rec)
                        report_mismatch("final_res", o_final_res, exp_rec.final_rec);
                end
                recs_seen++;
            end
            // Stretches with no stall alternate with random stall patterns.
            if (sending_done || ($time / 20000) % 3 == 0) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    // Corner cases: extreme fields, a single leaf, equal weights and zero weights.
    task automatic test_directed();
        send_leaf(8'd0, 16'hFFFF, 1'b1);
        send_leaf(8'd255, 16'h0000, 1'b1);
        send_leaf(8'hAA, 16'h5555, 1'b0);
        send_leaf(8'h55, 16'hAAAA, 1'b1);
        send_leaf(8'd1, 16'd7, 1'b0);
        send_leaf(8'd2, 16'd7, 1'b0);
        send_leaf(8'd3, 16'd7, 1'b0);
        send_leaf(8'd4, 16'd7, 1'b1);
        send_leaf(8'd9, 16'd0, 1'b0);
        send_leaf(8'd8, 16'd0, 1'b0);
        send_leaf(8'd7, 16'd0, 1'b1);
    endtask

    // Full heap: 32 leaves of all-ones weight bring the root sum close to the 21-bit
    // limit. Three more leaves are dropped, and the last of them still starts the build.
    task automatic test_full_heap();
        for (int k = 0; k < MaxLeaves + 3; k++)
            send_leaf(8'(k), 16'hFFFF, k == MaxLeaves + 2, k > 10);
    endtask

    // Random trees: mostly small and medium, some large up to full size. The weight ranges
    // are often narrow, so that ties are common.
    task automatic test_random_trees();
        int n;
        int sel;
        while (beats_sent < 235) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) n = 1;
            else if (sel < 80) n = $urandom_range(2, 12);
            else n = $urandom_range(13, MaxLeaves);
            send_tree(n, ($urandom_range(0, 1) ? 7 : 65535));
        end
    endtask

    // Back to back trees: a single leaf right after a tree checks that the counters
    // returned to zero.
    task automatic test_back_to_back();
        send_tree(3, 65535, 1'b0);
        send_leaf(8'd42, 16'd100, 1'b1, 1'b0);
        send_tree(2, 15, 1'b0);
    endtask

    initial begin
        int waited;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_symbol <= '0;
        i_weight <= '0;
        i_last <= 1'b0;
        heap_cnt = 0;
        int_next = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_heap();
        test_back_to_back();
        test_random_trees();
        i_valid <= 1'b0;
        sending_done = 1'b1;

        waited = 0;
        while (pending_recs.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (pending_recs.size() != 0)
            report_mismatch("records never delivered", 0, pending_recs.size());

        $display("Covered %0d leaf beats in %0d trees, including single leaves,", beats_sent,
                 trees_built);
        $display("full and overfull heaps, ties and large sums; %0d records checked.",
                 recs_seen);
        if (error_count == 0) begin
            $display("huffman_tree_builder_core regression: pass");
        end else begin
            $display("huffman_tree_builder_core regression: fail");
        end
        $finish;
    end

    // Generous limit for the whole run. The slowest case is every tree at full size
    // with the longest stalls, which is still far inside this time.
    initial begin
        #20ms;
        $display("huffman_tree_builder_core regression: fail");
        $finish;
    end
endmodule
